@@ hdl/lpps_pkg.sv @@
// Package: shared types, constants and the sensor position table of the line steering block.
package lpps_pkg;

  localparam int unsigned SENSOR_COUNT = 8;
  localparam int unsigned SAMPLE_BITS  = 12;
  localparam int unsigned CAL_BITS     = 48;
  localparam int unsigned GAIN_BITS    = 16;
  localparam int unsigned IDX_BITS     = 3;

  localparam logic [10:0] NORM_ONE    = 11'd1024;
  localparam logic [10:0] NOISE_FLOOR = 11'd51;
  localparam logic [10:0] PEAK_LEVEL  = 11'd512;
  localparam logic [16:0] DUTY_LIMIT  = 17'd120;

  localparam logic [CAL_BITS-1:0]  GREEN_RST = '0;
  localparam logic [CAL_BITS-1:0]  WHITE_RST = '0;
  localparam logic [GAIN_BITS-1:0] PROP_RST  = 16'd819;
  localparam logic [GAIN_BITS-1:0] DERIV_RST = 16'd410;
  localparam logic signed [7:0]    BASE_RST  = 8'sd100;

  // shared divider geometry: quotient must fit in DIV_Q_W bits
  localparam int unsigned DIV_DVD_W = 28;
  localparam int unsigned DIV_DVS_W = 12;
  localparam int unsigned DIV_Q_W   = 16;

  typedef enum logic [IDX_BITS-1:0] {
    CFG_GREEN_LO = 3'd0,
    CFG_GREEN_HI = 3'd1,
    CFG_WHITE_LO = 3'd2,
    CFG_WHITE_HI = 3'd3,
    CFG_PROP     = 3'd4,
    CFG_DERIV    = 3'd5,
    CFG_BASE     = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_NWAIT,
    ST_PEAK,
    ST_MAC,
    ST_CDIV,
    ST_CWAIT,
    ST_PROP,
    ST_DERIV,
    ST_DUTY
  } state_e;

  typedef struct packed {
    logic                 start;
    logic [DIV_DVD_W-1:0] dividend;
    logic [DIV_DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIV_Q_W-1:0] quotient;
  } div_rsp_t;

  // sensor centres in mm, Q8.8, sensor 0 leftmost
  function automatic logic signed [15:0] sensor_pos(input logic [IDX_BITS-1:0] idx);
    logic signed [15:0] p;
    case (idx)
      3'd0:    p = -16'sd29184;
      3'd1:    p = -16'sd20736;
      3'd2:    p = -16'sd13056;
      3'd3:    p = -16'sd4608;
      3'd4:    p = 16'sd4608;
      3'd5:    p = 16'sd13056;
      3'd6:    p = 16'sd20864;
      default: p = 16'sd29184;
    endcase
    return p;
  endfunction

endpackage

@@ hdl/lpps_if.sv @@
// Interfaces: sample input channel and steering result channel.
interface lpps_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] sample_0;
  logic [11:0] sample_1;
  logic [11:0] sample_2;
  logic [11:0] sample_3;
  logic [11:0] sample_4;
  logic [11:0] sample_5;
  logic [11:0] sample_6;
  logic [11:0] sample_7;
  modport source (output valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
                  sample_6, sample_7, input ready);
  modport sink (input valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
                sample_6, sample_7, output ready);
endinterface

interface lpps_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] duty_left;
  logic signed [7:0] duty_right;
  logic signed [15:0] line_position;
  logic [3:0]        peak_count;
  logic              left_exit;
  logic              right_exit;
  modport source (output valid, duty_left, duty_right, line_position, peak_count, left_exit,
                  right_exit, input ready);
  modport sink (input valid, duty_left, duty_right, line_position, peak_count, left_exit,
                right_exit, output ready);
endinterface

@@ hdl/lpps_div.sv @@
// Shared restoring divider: one quotient bit per cycle while a division is under way.
module lpps_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lpps_pkg::div_req_t  req_i,
  output lpps_pkg::div_rsp_t  rsp_o
);

  logic                               busy_q;
  logic                               done_q;
  logic [3:0]                         cnt_q;
  logic [lpps_pkg::DIV_DVS_W-1:0]     rem_q;
  logic [lpps_pkg::DIV_Q_W-1:0]       dq_q;
  logic [lpps_pkg::DIV_DVS_W-1:0]     dvs_q;
  logic [lpps_pkg::DIV_DVS_W:0]       trial;
  logic [lpps_pkg::DIV_DVS_W:0]       diff;
  logic                               ge;

  assign trial = {rem_q, dq_q[lpps_pkg::DIV_Q_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 4'd1;
      if (cnt_q == 4'd15) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      // upper bits are below the divisor by contract
      rem_q <= req_i.dividend[lpps_pkg::DIV_DVD_W-1:lpps_pkg::DIV_Q_W];
      dq_q  <= req_i.dividend[lpps_pkg::DIV_Q_W-1:0];
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[lpps_pkg::DIV_DVS_W-1:0] : trial[lpps_pkg::DIV_DVS_W-1:0];
      dq_q  <= {dq_q[lpps_pkg::DIV_Q_W-2:0], ge};
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dq_q;

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("divider started while busy");
  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q) else $error("divider did not start");
  a_done_after : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q) else $error("done without a finished division");

endmodule

@@ hdl/line_position_pd_steering.sv @@
// Top level: line position finder with PD steering of a differential drive.
// Each item carries eight 12-bit reflectance samples and yields one result: two wheel duties,
// the chosen line position in mm (Q8.8), the peak count and the outer-sensor exit flags.
// Work runs one item at a time through a sequencer around a single shared 16-step divider.
// The idle state takes the item. Each sensor is normalised, with a division where the ratio
// is neither zero nor saturated, and then checked for a peak. Each peak takes the neighbour
// sums, the divider start and the wait for the quotient. Steering and the hand-over to the
// output register follow; the hand-over waits until the output register is free or emptied.
// The input is not ready while an item is at work; a finished result sits in the output
// register while the next item is taken. Configuration writes go through a plain write port
// and must be made only while the block is idle.
module line_position_pd_steering (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lpps_pkg::IDX_BITS-1:0]     cfg_idx_i,
  input  logic [lpps_pkg::CAL_BITS-1:0]     cfg_wdata_i,
  lpps_in_if.sink                           in_i,
  lpps_out_if.source                        out_o
);

  localparam logic [lpps_pkg::IDX_BITS-1:0] LAST = 3'(lpps_pkg::SENSOR_COUNT - 1);

  // configuration registers
  logic [lpps_pkg::CAL_BITS-1:0]  green_lo_q, green_hi_q, white_lo_q, white_hi_q;
  logic [lpps_pkg::GAIN_BITS-1:0] prop_q, deriv_q;
  logic signed [7:0]              base_q;

  // working state
  lpps_pkg::state_e               state_q, state_d;
  logic [11:0]                    s_q [lpps_pkg::SENSOR_COUNT];
  logic [10:0]                    n_q [lpps_pkg::SENSOR_COUNT];
  logic [lpps_pkg::IDX_BITS-1:0]  ptr_q, pk_q;
  logic signed [27:0]             accv_q;
  logic [11:0]                    accs_q;
  logic [3:0]                     peaks_q;
  logic                           have_q;
  logic [16:0]                    best_q;
  logic signed [15:0]             pos_q, last_pos_q;
  logic                           left_on_q, right_on_q;
  logic signed [36:0]             turn_q;

  // result register
  logic                           out_valid_q;
  logic signed [7:0]              duty_l_q, duty_r_q;
  logic signed [15:0]             line_pos_q;
  logic [3:0]                     peak_cnt_q;
  logic                           exit_l_q, exit_r_q;

  lpps_pkg::div_req_t             div_req;
  lpps_pkg::div_rsp_t             div_rsp;

  lpps_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      green_lo_q <= lpps_pkg::GREEN_RST;
      green_hi_q <= lpps_pkg::GREEN_RST;
      white_lo_q <= lpps_pkg::WHITE_RST;
      white_hi_q <= lpps_pkg::WHITE_RST;
      prop_q     <= lpps_pkg::PROP_RST;
      deriv_q    <= lpps_pkg::DERIV_RST;
      base_q     <= lpps_pkg::BASE_RST;
    end else if (cfg_we_i) begin
      case (lpps_pkg::cfg_idx_e'(cfg_idx_i))
        lpps_pkg::CFG_GREEN_LO: green_lo_q <= cfg_wdata_i;
        lpps_pkg::CFG_GREEN_HI: green_hi_q <= cfg_wdata_i;
        lpps_pkg::CFG_WHITE_LO: white_lo_q <= cfg_wdata_i;
        lpps_pkg::CFG_WHITE_HI: white_hi_q <= cfg_wdata_i;
        lpps_pkg::CFG_PROP:     prop_q     <= cfg_wdata_i[lpps_pkg::GAIN_BITS-1:0];
        lpps_pkg::CFG_DERIV:    deriv_q    <= cfg_wdata_i[lpps_pkg::GAIN_BITS-1:0];
        lpps_pkg::CFG_BASE:     base_q     <= cfg_wdata_i[7:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------- normalisation terms
  logic [lpps_pkg::CAL_BITS-1:0] g_word, w_word;
  logic [11:0]        g_cur, w_cur, s_cur;
  logic signed [12:0] num, span;
  logic [11:0]        num_abs, span_abs;
  logic               norm_zero, norm_sat;

  assign g_word = ptr_q[2] ? green_hi_q : green_lo_q;
  assign w_word = ptr_q[2] ? white_hi_q : white_lo_q;
  assign g_cur  = g_word[ptr_q[1:0]*lpps_pkg::SAMPLE_BITS +: lpps_pkg::SAMPLE_BITS];
  assign w_cur  = w_word[ptr_q[1:0]*lpps_pkg::SAMPLE_BITS +: lpps_pkg::SAMPLE_BITS];
  assign s_cur  = s_q[ptr_q];
  assign num    = $signed({1'b0, s_cur}) - $signed({1'b0, g_cur});
  assign span   = $signed({1'b0, w_cur}) - $signed({1'b0, g_cur});
  assign num_abs  = num[12]  ? 12'(-num)  : num[11:0];
  assign span_abs = span[12] ? 12'(-span) : span[11:0];
  // opposite signs or a zero term give zero; a ratio of one or more saturates
  assign norm_zero = (span == '0) || (num == '0) || (num[12] != span[12]);
  assign norm_sat  = num_abs >= span_abs;

  // ---------------------------------------------------------------- peak terms
  logic [10:0]                   n_cur;
  logic [lpps_pkg::IDX_BITS-1:0] win_lo, win_hi;
  logic signed [27:0]            prod;
  logic [27:0]                   accv_abs;
  logic signed [15:0]            cent;
  logic signed [16:0]            dist_s;
  logic [16:0]                   pk_dist;

  assign n_cur    = n_q[ptr_q];
  assign win_lo   = (pk_q == '0) ? '0 : pk_q - 3'd1;
  assign win_hi   = (pk_q == LAST) ? LAST : pk_q + 3'd1;
  assign prod     = $signed({17'b0, n_cur}) * 28'(lpps_pkg::sensor_pos(ptr_q));
  assign accv_abs = accv_q[27] ? 28'(-accv_q) : accv_q;
  // quotient stays below 2^15: the centroid lies between sensor positions
  assign cent     = accv_q[27] ? -$signed(div_rsp.quotient) : $signed(div_rsp.quotient);
  assign dist_s   = 17'(cent) - 17'(last_pos_q);
  assign pk_dist  = dist_s[16] ? 17'(-dist_s) : dist_s;

  // ---------------------------------------------------------------- steering terms
  logic signed [16:0] pos_diff;
  logic signed [36:0] p_term, d_term, base_q20, sum_l, sum_r;
  logic signed [7:0]  duty_l, duty_r;
  logic               on_l, on_r;
  logic [12:0]        thr_l, thr_r;

  assign pos_diff = 17'(pos_q) - 17'(last_pos_q);
  assign p_term   = $signed({21'b0, prop_q}) * 37'(pos_q);
  assign d_term   = $signed({21'b0, deriv_q}) * 37'(pos_diff);
  assign base_q20 = 37'(base_q) <<< 20;
  // turn_q holds the PD sum; it is added on the left and taken off on the right
  assign sum_l    = base_q20 + turn_q;
  assign sum_r    = base_q20 - turn_q;

  function automatic logic signed [7:0] sat_duty(input logic signed [36:0] x);
    logic [36:0] mag;
    logic [16:0] ip;
    logic [7:0]  sat;
    mag = x[36] ? 37'(-x) : x;
    ip  = mag[36:20];
    sat = (ip > lpps_pkg::DUTY_LIMIT) ? lpps_pkg::DUTY_LIMIT[7:0] : ip[7:0];
    return x[36] ? $signed(-sat) : $signed(sat);
  endfunction

  assign duty_l = sat_duty(sum_l);
  assign duty_r = sat_duty(sum_r);
  assign thr_l  = 13'(white_lo_q[11:0]) + 13'(green_lo_q[11:0]);
  assign thr_r  = 13'(white_hi_q[47:36]) + 13'(green_hi_q[47:36]);
  assign on_l   = {s_q[0], 1'b0} >= thr_l;
  assign on_r   = {s_q[LAST], 1'b0} >= thr_r;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      lpps_pkg::ST_IDLE:  if (in_i.valid) state_d = lpps_pkg::ST_NORM;
      lpps_pkg::ST_NORM: begin
        if (!norm_zero && !norm_sat) state_d = lpps_pkg::ST_NWAIT;
        else if (ptr_q == LAST)     state_d = lpps_pkg::ST_PEAK;
      end
      lpps_pkg::ST_NWAIT: begin
        if (div_rsp.done) state_d = (ptr_q == LAST) ? lpps_pkg::ST_PEAK : lpps_pkg::ST_NORM;
      end
      lpps_pkg::ST_PEAK: begin
        if (n_cur > lpps_pkg::PEAK_LEVEL) state_d = lpps_pkg::ST_MAC;
        else if (ptr_q == LAST)          state_d = lpps_pkg::ST_PROP;
      end
      lpps_pkg::ST_MAC:   if (ptr_q == win_hi) state_d = lpps_pkg::ST_CDIV;
      lpps_pkg::ST_CDIV:  state_d = lpps_pkg::ST_CWAIT;
      lpps_pkg::ST_CWAIT: begin
        if (div_rsp.done) state_d = (pk_q == LAST) ? lpps_pkg::ST_PROP : lpps_pkg::ST_PEAK;
      end
      lpps_pkg::ST_PROP:  state_d = lpps_pkg::ST_DERIV;
      lpps_pkg::ST_DERIV: state_d = lpps_pkg::ST_DUTY;
      lpps_pkg::ST_DUTY:  if (!out_valid_q || out_o.ready) state_d = lpps_pkg::ST_IDLE;
      default:            state_d = lpps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {6'b0, num_abs, 10'b0};
    div_req.divisor  = span_abs;
    case (state_q)
      lpps_pkg::ST_IDLE: in_i.ready = 1'b1;
      lpps_pkg::ST_NORM: div_req.start = !norm_zero && !norm_sat;
      lpps_pkg::ST_CDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = accv_abs;
        div_req.divisor  = accs_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= lpps_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  // control registers of the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      pk_q        <= '0;
      peaks_q     <= '0;
      have_q      <= 1'b0;
      last_pos_q  <= '0;
      left_on_q   <= 1'b0;
      right_on_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // load a new result when the register is free or being emptied
      if (state_q == lpps_pkg::ST_DUTY && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        lpps_pkg::ST_IDLE: begin
          ptr_q   <= '0;
          peaks_q <= '0;
          have_q  <= 1'b0;
        end
        lpps_pkg::ST_NORM:  if (norm_zero || norm_sat) ptr_q <= ptr_q + 3'd1;
        lpps_pkg::ST_NWAIT: if (div_rsp.done) ptr_q <= ptr_q + 3'd1;
        lpps_pkg::ST_PEAK: begin
          if (n_cur > lpps_pkg::PEAK_LEVEL) begin
            pk_q  <= ptr_q;
            ptr_q <= (ptr_q == '0) ? '0 : ptr_q - 3'd1;
          end else begin
            ptr_q <= ptr_q + 3'd1;
          end
        end
        lpps_pkg::ST_MAC: if (ptr_q != win_hi) ptr_q <= ptr_q + 3'd1;
        lpps_pkg::ST_CWAIT: begin
          if (div_rsp.done) begin
            ptr_q   <= pk_q + 3'd1;
            peaks_q <= peaks_q + 4'd1;
            have_q  <= 1'b1;
          end
        end
        lpps_pkg::ST_DUTY: begin
          if (!out_valid_q || out_o.ready) begin
            last_pos_q  <= pos_q;
            left_on_q   <= on_l;
            right_on_q  <= on_r;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      lpps_pkg::ST_IDLE: begin
        pos_q <= last_pos_q;
        if (in_i.valid) begin
          s_q[0] <= in_i.sample_0;
          s_q[1] <= in_i.sample_1;
          s_q[2] <= in_i.sample_2;
          s_q[3] <= in_i.sample_3;
          s_q[4] <= in_i.sample_4;
          s_q[5] <= in_i.sample_5;
          s_q[6] <= in_i.sample_6;
          s_q[7] <= in_i.sample_7;
        end
      end
      lpps_pkg::ST_NORM: begin
        if (norm_zero)     n_q[ptr_q] <= '0;
        else if (norm_sat) n_q[ptr_q] <= lpps_pkg::NORM_ONE;
      end
      lpps_pkg::ST_NWAIT: begin
        if (div_rsp.done) begin
          n_q[ptr_q] <= (div_rsp.quotient[10:0] <= lpps_pkg::NOISE_FLOOR) ? '0
                                                                       : div_rsp.quotient[10:0];
        end
      end
      lpps_pkg::ST_PEAK: begin
        accv_q <= '0;
        accs_q <= '0;
      end
      lpps_pkg::ST_MAC: begin
        accv_q <= accv_q + prod;
        accs_q <= accs_q + 12'(n_cur);
      end
      lpps_pkg::ST_CWAIT: begin
        // keep the leftmost of equally near peaks
        if (div_rsp.done && (!have_q || pk_dist < best_q)) begin
          best_q <= pk_dist;
          pos_q  <= cent;
        end
      end
      lpps_pkg::ST_PROP:  turn_q <= p_term;
      lpps_pkg::ST_DERIV: turn_q <= turn_q + d_term;
      lpps_pkg::ST_DUTY: begin
        if (!out_valid_q || out_o.ready) begin
          duty_l_q   <= duty_l;
          duty_r_q   <= duty_r;
          line_pos_q <= pos_q;
          peak_cnt_q <= peaks_q;
          exit_l_q   <= left_on_q && !on_l;
          exit_r_q   <= right_on_q && !on_r;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.duty_left     = duty_l_q;
  assign out_o.duty_right    = duty_r_q;
  assign out_o.line_position = line_pos_q;
  assign out_o.peak_count    = peak_cnt_q;
  assign out_o.left_exit     = exit_l_q;
  assign out_o.right_exit    = exit_r_q;

  a_duty_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (duty_l_q <= 8'sd120 && duty_l_q >= -8'sd120 &&
                     duty_r_q <= 8'sd120 && duty_r_q >= -8'sd120))
    else $error("duty outside limit");
  a_peak_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> peak_cnt_q <= 4'd8) else $error("peak count too large");
  a_centroid_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lpps_pkg::ST_CDIV |-> accs_q > 12'(lpps_pkg::PEAK_LEVEL))
    else $error("centroid weight too small");
  a_div_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lpps_pkg::ST_IDLE) |-> !div_rsp.busy) else $error("divider busy while idle");

endmodule
